/* hw/rtl/pdfhex_pkg.sv */
`timescale 1ns / 1ps

package pdfhex_pkg;

	// parenthesis depth counter width
	localparam int DEPTH_BITS = 8;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

	// most results one input byte can cause
	localparam int MAX_RESULTS = 3;

	localparam logic [7:0] CH_LT    = 8'h3C; // '<'
	localparam logic [7:0] CH_GT    = 8'h3E; // '>'
	localparam logic [7:0] CH_LPAR  = 8'h28; // '('
	localparam logic [7:0] CH_RPAR  = 8'h29; // ')'
	localparam logic [7:0] CH_BSL   = 8'h5C; // backslash
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UC_A  = 8'h41;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [7:0]            first_token_byte;
		logic [7:0]            second_token_byte;
		logic [1:0]            token_length;
		logic                  inside_text_block;
		logic                  inside_string;
		logic [DEPTH_BITS-1:0] nesting_depth;
		logic                  escape_pending;
	} parse_state_t;

	// bytes produced by one input byte, in output order
	typedef struct packed {
		logic [1:0]                       cnt;
		logic [MAX_RESULTS-1:0][7:0]      bytes;
	} run_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_UC_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

/* hw/rtl/pdfhex_step.sv */
`timescale 1ns / 1ps

module pdfhex_step (
	input  pdfhex_pkg::parse_state_t cur,
	input  pdfhex_pkg::in_item_t     item,
	output pdfhex_pkg::parse_state_t nxt,
	output pdfhex_pkg::run_t         res
);

	always_comb begin
		logic [7:0]                        b;
		logic [pdfhex_pkg::DEPTH_BITS-1:0] d;
		b   = item.data_byte;
		d   = cur.nesting_depth;
		nxt = cur;
		res = '0;

		if (cur.inside_string) begin
			if (cur.escape_pending) begin
				nxt.escape_pending = 1'b0;
				res.bytes[0] = pdfhex_pkg::hex_digit(b[7:4]);
				res.bytes[1] = pdfhex_pkg::hex_digit(b[3:0]);
				res.cnt      = 2'd2;
			end else if (b == pdfhex_pkg::CH_BSL) begin
				nxt.escape_pending = 1'b1;
			end else begin
				if (b == pdfhex_pkg::CH_LPAR && d != pdfhex_pkg::DEPTH_MAX) begin
					d = d + pdfhex_pkg::DEPTH_ONE;
				end
				if (b == pdfhex_pkg::CH_RPAR && d != '0) begin
					d = d - pdfhex_pkg::DEPTH_ONE;
				end
				nxt.nesting_depth = d;
				if (d == '0) begin
					nxt.inside_string = 1'b0;
					res.bytes[0] = pdfhex_pkg::CH_GT;
					res.cnt      = 2'd1;
				end else begin
					res.bytes[0] = pdfhex_pkg::hex_digit(b[7:4]);
					res.bytes[1] = pdfhex_pkg::hex_digit(b[3:0]);
					res.cnt      = 2'd2;
				end
			end
		end else begin
			// token tracking on the first two bytes
			if (!pdfhex_pkg::is_space(b)) begin
				if (cur.token_length == 2'd0) begin
					nxt.first_token_byte = b;
					nxt.token_length     = 2'd1;
				end else if (cur.token_length == 2'd1) begin
					nxt.second_token_byte = b;
					nxt.token_length      = 2'd2;
				end
			end else begin
				nxt.first_token_byte  = '0;
				nxt.second_token_byte = '0;
				nxt.token_length      = 2'd0;
			end
			if (nxt.token_length == 2'd2 && nxt.second_token_byte == pdfhex_pkg::CH_T) begin
				if (nxt.first_token_byte == pdfhex_pkg::CH_B) begin
					nxt.inside_text_block = 1'b1;
				end else if (nxt.first_token_byte == pdfhex_pkg::CH_E) begin
					nxt.inside_text_block = 1'b0;
				end
			end
			if (nxt.inside_text_block && b == pdfhex_pkg::CH_LPAR) begin
				nxt.inside_string  = 1'b1;
				nxt.nesting_depth  = pdfhex_pkg::DEPTH_ONE;
				nxt.escape_pending = 1'b0;
				res.bytes[0]       = pdfhex_pkg::CH_LT;
			end else begin
				res.bytes[0] = b;
			end
			res.cnt = 2'd1;
		end

		// end of file closes an open string and clears everything
		if (item.end_of_file) begin
			if (nxt.inside_string) begin
				res.bytes[res.cnt] = pdfhex_pkg::CH_GT;
				res.cnt            = res.cnt + 2'd1;
			end
			nxt = '0;
		end
	end

endmodule

/* hw/rtl/pdf_text_string_hex_rewriter_unit.sv */
`timescale 1ns / 1ps

// channel | direction | handshake                    | payload
// byte    | in        | byte_valid / byte_stall      | byte_item (data_byte, end_of_file)
// run     | out       | run_valid / run_stall        | run_item (out_byte, last_of_run)
//
// an input item sits in a one-entry input register; when it advances, the parser
// state is updated and its zero to three output bytes load the run buffer
// each output byte takes one cycle on the run channel while run_stall is low; an item
// with results advances once the buffer is empty or its last byte is taken; items with no result never wait
// arst_n clears parser state, input valid and the run buffer count
// run_stall holds the current byte; byte_stall rises only while the input item waits

module pdf_text_string_hex_rewriter_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  pdfhex_pkg::in_item_t  byte_item,
	output logic                  run_valid,
	input  logic                  run_stall,
	output pdfhex_pkg::out_item_t run_item
);

	// input register
	logic                 valid_s1;
	pdfhex_pkg::in_item_t item_s1;

	// parser state
	pdfhex_pkg::parse_state_t state_q;
	pdfhex_pkg::parse_state_t state_nxt;
	pdfhex_pkg::run_t         step_res;

	// run buffer: bytes of the item being delivered
	logic [1:0]                               run_cnt_q;
	logic [1:0]                               run_pos_q;
	logic [pdfhex_pkg::MAX_RESULTS-1:0][7:0]  run_byte_q;

	logic out_take;
	logic last_take;
	logic buf_free;
	logic advance;
	logic in_take;

	pdfhex_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (step_res)
	);

	assign run_valid = (run_cnt_q != 2'd0);
	assign out_take  = run_valid && !run_stall;
	assign last_take = out_take && (run_pos_q == 2'(run_cnt_q - 2'd1));
	assign buf_free  = (run_cnt_q == 2'd0) || last_take;

	// an item moves on when its bytes fit in the buffer, or when it makes none
	assign advance    = valid_s1 && (buf_free || step_res.cnt == 2'd0);
	assign byte_stall = valid_s1 && !advance;
	assign in_take    = byte_valid && !byte_stall;

	assign run_item.out_byte    = run_byte_q[run_pos_q];
	assign run_item.last_of_run = (run_pos_q == 2'(run_cnt_q - 2'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			state_q   <= '0;
			run_cnt_q <= 2'd0;
			run_pos_q <= 2'd0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance && step_res.cnt != 2'd0) begin
				run_cnt_q <= step_res.cnt;
				run_pos_q <= 2'd0;
			end else if (last_take) begin
				run_cnt_q <= 2'd0;
				run_pos_q <= 2'd0;
			end else if (out_take) begin
				run_pos_q <= run_pos_q + 2'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= byte_item;
		end
		if (advance && step_res.cnt != 2'd0) begin
			run_byte_q <= step_res.bytes;
		end
	end

endmodule
